/* hdl/mmr_pkg.sv */
// Shared types and constants for the modulation matrix router.
package mmr_pkg;

  // Input item function codes
  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_UPDATE = 2'd2
  } func_t;

  // One routing slot as held in the slot memory
  typedef struct packed {
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] tmin;
    logic [15:0] tmax;
    logic [31:0] dmin;
    logic [31:0] dmax;
  } slot_t;

  // Divider width plan: 16-bit divisor, 32-bit quotient, 48-bit dividend
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 6;

  // Start request to the shared divider
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  // Q16.16 one, and the integer part mask
  localparam logic [31:0] FRAC_ONE  = 32'h0001_0000;
  localparam logic [31:0] INT_MASK  = 32'hFFFF_0000;

endpackage

/* hdl/mmr_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module mmr_div import mmr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [31:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [15:0]          rem;
  logic [15:0]          divisor_r;
  logic [31:0]          dq;
  logic [16:0]          rem_sh;
  logic [16:0]          rem_diff;
  logic                 take;

  // Trial subtract of the shifted remainder
  assign rem_sh   = {rem, dq[31]};
  assign rem_diff = rem_sh - {1'b0, divisor_r};
  assign take     = rem_sh >= {1'b0, divisor_r};
  assign quotient = dq;

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load the upper dividend bits as remainder, shift quotient bits in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem       <= req.dividend[47:32];
      dq        <= req.dividend[31:0];
      divisor_r <= req.divisor;
    end else if (busy) begin
      rem <= take ? rem_diff[15:0] : rem_sh[15:0];
      dq  <= {dq[30:0], take};
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < divisor_r))
    else $error("divider remainder not below divisor");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("divider done without a finished run");
`endif

endmodule

/* hdl/mmr_store.sv */
// Slot table and source sample memories with eligibility and written flags.
module mmr_store import mmr_pkg::*; #(
  parameter int SLOTS   = 8,
  parameter int SOURCES = 16,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              slot_we,
  input  logic [SLOT_W-1:0] slot_waddr,
  input  logic              slot_welig,
  input  slot_t             slot_wdata,
  input  logic              slot_re,
  input  logic [SLOT_W-1:0] slot_raddr,
  output slot_t             slot_rdata,
  input  logic              src_we,
  input  logic [SRC_W-1:0]  src_waddr,
  input  logic [31:0]       src_wdata,
  input  logic              src_re,
  input  logic [SRC_W-1:0]  src_raddr,
  input  logic              src_rin,
  output logic [31:0]       src_rdata,
  output logic              src_rok,
  output logic [SLOTS-1:0]  eligible
);

  slot_t              slot_mem [SLOTS];
  logic [31:0]        src_mem  [SOURCES];
  logic [SOURCES-1:0] src_written;

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata <= slot_mem[slot_raddr];
    end
  end

  // Source memory; an unwritten or out-of-range source reads with src_rok low
  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    if (src_re) begin
      src_rdata <= src_mem[src_raddr];
      src_rok   <= src_rin && src_written[src_raddr];
    end
  end

  // Flags cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      eligible    <= '0;
      src_written <= '0;
    end else begin
      if (slot_we) begin
        eligible[slot_waddr] <= slot_welig;
      end
      if (src_we) begin
        src_written[src_waddr] <= 1'b1;
      end
    end
  end

endmodule

/* hdl/modulation_matrix_router.sv */
// Top level of the modulation matrix router: sequencer and mapping datapath.
//
// Input channel (in_valid/in_ready) takes one request: write a slot, store a
// source sample, or run an update pass. An update pass walks all SLOTS slots
// in order, skipping inactive slots. An active slot whose sample lies inside
// the threshold window goes through the shared 32-step divider that scales
// the window onto the output window; a value that clamps to a window end
// skips the divider.
// in_ready is high only while no pass is running.
// Output channel (out_valid/out_ready) carries one result per active slot;
// last marks the final result of the pass. A one-entry output register
// holds a result; if the receiver stalls, the pass waits at the next result.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes the
// integer destination mask; write it only while the block is idle.
// Reset (rst, synchronous) marks all slots inactive, all source samples
// zero and clears the mask; it needs no clearing pass.
module modulation_matrix_router import mmr_pkg::*; #(
  parameter int SLOTS        = 8,
  parameter int SOURCES      = 16,
  parameter int DESTINATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [2:0]         slot_index,
  input  logic               slot_active,
  input  logic [3:0]         source_select,
  input  logic [3:0]         dest_select,
  input  logic [15:0]        threshold_min,
  input  logic [15:0]        threshold_max,
  input  logic signed [31:0] dest_min,
  input  logic signed [31:0] dest_max,
  input  logic signed [31:0] source_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         dest_index,
  output logic signed [31:0] dest_value,
  output logic               last
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_SRC  = 8'b0000_0100,
    S_LOAD = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] idx;
  logic [15:0]      integer_dest_mask;

  logic             in_fire;
  logic             slot_we;
  logic             slot_welig;
  slot_t            slot_wdata;
  logic             src_we;
  slot_t            slot_q;
  logic [31:0]      src_rdata;
  logic             src_rok;
  logic [SLOTS-1:0] eligible;
  logic             walk_done;
  logic             later;

  logic [32:0]      num_r;
  logic [16:0]      den_r;
  logic [32:0]      span_r;
  logic             last_r;
  logic [31:0]      val;

  logic [32:0]      num_abs;
  logic [16:0]      den_abs;
  logic [32:0]      span_abs;
  logic             take_min;
  logic             take_max;
  div_req_t         div_req;
  logic             div_done;
  logic [31:0]      div_q;
  logic [33:0]      q_signed;
  logic [33:0]      sum;
  logic             out_load;
  logic             int_dst;
  logic [31:0]      val_int;
  logic [31:0]      out_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Decode slot and sample writes; out-of-range targets are dropped
  assign slot_we    = in_fire && (func == FUNC_WRITE) && (32'(slot_index) < SLOTS);
  assign slot_welig = slot_active && (32'(dest_select) < DESTINATIONS);
  assign src_we     = in_fire && (func == FUNC_SAMPLE) && (32'(source_select) < SOURCES);

  always_comb begin
    slot_wdata.src  = source_select;
    slot_wdata.dst  = dest_select;
    slot_wdata.tmin = threshold_min;
    slot_wdata.tmax = threshold_max;
    slot_wdata.dmin = dest_min;
    slot_wdata.dmax = dest_max;
  end

  mmr_store #(
    .SLOTS   (SLOTS),
    .SOURCES (SOURCES)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .slot_we    (slot_we),
    .slot_waddr (SLOT_W'(slot_index)),
    .slot_welig (slot_welig),
    .slot_wdata (slot_wdata),
    .slot_re    (state == S_SCAN),
    .slot_raddr (idx[SLOT_W-1:0]),
    .slot_rdata (slot_q),
    .src_we     (src_we),
    .src_waddr  (SRC_W'(source_select)),
    .src_wdata  (source_value),
    .src_re     (state == S_SRC),
    .src_raddr  (SRC_W'(slot_q.src)),
    .src_rin    (32'(slot_q.src) < SOURCES),
    .src_rdata  (src_rdata),
    .src_rok    (src_rok),
    .eligible   (eligible)
  );

  assign walk_done = (idx == CNT_W'(SLOTS));

  // Any eligible slot after the current one
  always_comb begin
    later = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (eligible[j] && (CNT_W'(j) > idx)) begin
        later = 1'b1;
      end
    end
  end

  // Magnitudes and window decision
  always_comb begin
    num_abs  = num_r[32] ? (~num_r + 33'd1) : num_r;
    den_abs  = den_r[16] ? (~den_r + 17'd1) : den_r;
    span_abs = span_r[32] ? (~span_r + 33'd1) : span_r;
    take_min = (den_r == '0) || (num_r == '0) || (num_r[32] != den_r[16]);
    take_max = num_abs >= {17'b0, den_abs[15:0]};
  end

  // Start the divider on |num| * |span| / |den| inside the window
  always_comb begin
    div_req.start    = (state == S_MUL) && !take_min && !take_max;
    div_req.dividend = 48'(num_abs[15:0]) * 48'(span_abs[31:0]);
    div_req.divisor  = den_abs[15:0];
  end

  mmr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Apply the span sign and offset by the window minimum
  assign q_signed = span_r[32] ? (~{2'b0, div_q} + 34'd1) : {2'b0, div_q};
  assign sum      = {{2{slot_q.dmin[31]}}, slot_q.dmin} + q_signed;

  // Clear the fraction for integer destinations, truncating toward zero
  assign int_dst  = integer_dest_mask[slot_q.dst];
  assign val_int  = (val[31] && (val[15:0] != 16'd0)) ? ((val & INT_MASK) + FRAC_ONE)
                                                      : (val & INT_MASK);
  assign out_val  = int_dst ? val_int : val;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && (func == FUNC_UPDATE)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (walk_done) begin
          state_next = S_IDLE;
        end else if (eligible[idx[SLOT_W-1:0]]) begin
          state_next = S_SRC;
        end
      end
      S_SRC:  state_next = S_LOAD;
      S_LOAD: state_next = S_MUL;
      S_MUL: begin
        state_next = (take_min || take_max) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN:  state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      idx               <= '0;
      out_valid         <= 1'b0;
      integer_dest_mask <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        integer_dest_mask <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE) begin
        idx <= '0;
      end else if ((state == S_SCAN) && !walk_done && !eligible[idx[SLOT_W-1:0]]) begin
        idx <= idx + CNT_W'(1);
      end else if (out_load) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_SRC) begin
      last_r <= !later;
    end
    if (state == S_LOAD) begin
      num_r  <= {src_rok & src_rdata[31], src_rok ? src_rdata : 32'd0}
                - {17'b0, slot_q.tmin};
      den_r  <= {1'b0, slot_q.tmax} - {1'b0, slot_q.tmin};
      span_r <= {slot_q.dmax[31], slot_q.dmax} - {slot_q.dmin[31], slot_q.dmin};
    end
    if (state == S_MUL) begin
      val <= take_min ? slot_q.dmin : slot_q.dmax;
    end
    if (state == S_FIN) begin
      val <= sum[31:0];
    end
    if (out_load) begin
      dest_index <= slot_q.dst;
      dest_value <= out_val;
      last       <= last_r;
    end
  end

`ifndef SYNTH
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(dest_index) &&
                                   $stable(dest_value) && $stable(last)))
    else $error("result changed or dropped while stalled");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");
`endif

endmodule
